>>> hdl/temporal_frame_average_macros.svh
// assertion helpers, compiled away for synthesis
`ifndef TEMPORAL_FRAME_AVERAGE_MACROS_SVH
`define TEMPORAL_FRAME_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define TFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// antecedent followed by consequent in the next cycle
`define TFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TFA_ASSERT(lbl, prop, msg)
`define TFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/tfa_pkg.sv
`timescale 1ns / 1ps

package tfa_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 3;
  localparam int WORD_W     = NUM_CH * PIX_W;
  localparam int ORDER_W    = 3;
  localparam int FRAME_W    = 17;
  // seven frames of 255 at most
  localparam int SUM_W      = 11;
  localparam int DEN_W      = ORDER_W + 1;
  localparam int NUM_W      = DEN_W + PIX_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam int DEF_MAX_ORDER    = 8;
  localparam int DEF_FRAME_PIXELS = 65536;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = CFG_IDX_W'(1);

  localparam logic [ORDER_W-1:0] FILTER_ORDER_RST = ORDER_W'(1);
  localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = FRAME_W'(65536);

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_FETCH,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

endpackage

>>> hdl/tfa_if.sv
`timescale 1ns / 1ps

interface tfa_pix_if;
  import tfa_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t in_ch0;
  pixel_t in_ch1;
  pixel_t in_ch2;
  modport source (output valid, in_ch0, in_ch1, in_ch2, input ready);
  modport sink   (input valid, in_ch0, in_ch1, in_ch2, output ready);
endinterface

interface tfa_res_if;
  import tfa_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t out_ch0;
  pixel_t out_ch1;
  pixel_t out_ch2;
  logic   last_pixel;
  modport source (output valid, out_ch0, out_ch1, out_ch2, last_pixel, input ready);
  modport sink   (input valid, out_ch0, out_ch1, out_ch2, last_pixel, output ready);
endinterface

interface tfa_cfg_if;
  import tfa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/tfa_frame_mem.sv
`timescale 1ns / 1ps

module tfa_frame_mem #(
  parameter int ADDR_W = 19
) (
  input  logic                clk,
  input  logic                we,
  input  logic                re,
  input  logic [ADDR_W-1:0]   addr,
  input  tfa_pkg::word_t      wdata,
  output tfa_pkg::word_t      rdata
);
  import tfa_pkg::*;

  word_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/tfa_round_div.sv
`timescale 1ns / 1ps

module tfa_round_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [tfa_pkg::ORDER_W-1:0] order,
  input  tfa_pkg::sum_t          sum [tfa_pkg::NUM_CH],
  output logic                   done,
  output tfa_pkg::pixel_t        quot [tfa_pkg::NUM_CH]
);
  import tfa_pkg::*;

  localparam int CNT_W = $clog2(PIX_W + 1);

  // per lane: remainder in the top DEN_W bits, numerator then quotient below
  logic [NUM_W-1:0] acc [NUM_CH];
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_sh  [NUM_CH];
  logic [DEN_W-1:0] rem_new [NUM_CH];
  logic             q_bit   [NUM_CH];

  // (2*sum + n) / (2*n) gives the mean rounded half up
  assign den = {order, 1'b0};

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      rem_sh[i] = acc[i][NUM_W-1:PIX_W-1];
      q_bit[i]  = (rem_sh[i] >= {1'b0, den});
      if (q_bit[i]) begin
        rem_new[i] = DEN_W'(rem_sh[i] - {1'b0, den});
      end else begin
        rem_new[i] = rem_sh[i][DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(PIX_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CH; i++) begin
      if (start) begin
        acc[i] <= NUM_W'({sum[i], 1'b0}) + NUM_W'(order);
      end else if (cnt != '0) begin
        acc[i] <= {rem_new[i], acc[i][PIX_W-2:0], q_bit[i]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      quot[i] = acc[i][PIX_W-1:0];
    end
  end

endmodule

>>> hdl/temporal_frame_average.sv
`timescale 1ns / 1ps
// Temporal moving average over whole frames of three-channel 8-bit pixels.
// Pixels arrive in raster order on the pixel channel; each one is stored in
// the current frame slot and, once filter_order frames are held, the result
// channel gets the per-channel rounded mean of that position over the slots
// with last_pixel marking the end of a frame. Until then a pixel is stored
// and gives no result.
// The cfg channel writes filter_order (index 0) and frame_pixels (index 1);
// it is always ready, and the user writes it only while no pixel is in
// work; the block itself does not enforce this. A pixel that gives no
// result is accepted and written only. Otherwise it is accepted, written,
// then read once per averaged slot from the frame store on the single
// memory port until the last read lands in the sums; eight steps of the
// shared restoring divider on all three channels follow, then a completion
// flag and the result register.
// A finished result waits in the output register, so the next pixel is taken
// while the receiver stalls; a pixel whose result finds that register still
// full waits until the transfer. Reset clears the slot marks, the slot and
// position counters and the registers (filter_order 1, frame_pixels 65536);
// the frame store itself is not cleared.
`include "temporal_frame_average_macros.svh"

module temporal_frame_average #(
  parameter int MAX_ORDER    = tfa_pkg::DEF_MAX_ORDER,
  parameter int FRAME_PIXELS = tfa_pkg::DEF_FRAME_PIXELS
) (
  input logic        clk,
  input logic        rst,
  tfa_pix_if.sink    pixel,
  tfa_res_if.source  result,
  tfa_cfg_if.sink    cfg
);
  import tfa_pkg::*;

  localparam int SLOT_W = $clog2(MAX_ORDER);
  localparam int POS_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int SIZE_W = $clog2(FRAME_PIXELS + 1);
  localparam int ADDR_W = SLOT_W + POS_W;

  state_t state, state_next;

  logic [ORDER_W-1:0]   filter_order;
  logic [FRAME_W-1:0]   frame_pixels;
  logic [SLOT_W-1:0]    ring_slot;
  logic [POS_W-1:0]     pixel_index;
  logic [MAX_ORDER-1:0] slot_written;

  logic [SLOT_W-1:0]  cur_slot;
  logic [POS_W-1:0]   pos_r;
  logic               last_r;
  logic               gate_r;
  word_t              pix_r;
  logic [ORDER_W-1:0] fetch_idx;
  logic               rd_pend;
  sum_t               sum [NUM_CH];

  logic               res_valid;
  pixel_t             res_ch [NUM_CH];
  logic               res_last;

  logic [SIZE_W-1:0]  size;
  logic [POS_W-1:0]   pos;
  logic               last;
  logic               gate;
  logic [SLOT_W:0]    slot_inc;
  logic [ORDER_W-1:0] cfg_order;

  logic               pix_ready;
  logic               pix_xfer;
  logic               mem_we;
  logic               mem_re;
  logic               fetch_done;
  logic               div_start;
  logic               div_done;
  logic               out_load;
  logic [ADDR_W-1:0]  mem_addr;
  word_t              mem_rdata;
  pixel_t             quot [NUM_CH];

  // config port
  assign cfg.ready = 1'b1;
  assign cfg_order = cfg.data[ORDER_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= FILTER_ORDER_RST;
      frame_pixels <= FRAME_PIXELS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FILTER_ORDER: begin
          // out-of-range orders are dropped
          if (cfg_order != '0 && 32'(cfg_order) < 32'(MAX_ORDER)) begin
            filter_order <= cfg_order;
          end
        end
        REG_FRAME_PIXELS: frame_pixels <= cfg.data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size clamped to 1..FRAME_PIXELS
  always_comb begin
    if (frame_pixels == '0) begin
      size = SIZE_W'(1);
    end else if (32'(frame_pixels) > 32'(FRAME_PIXELS)) begin
      size = SIZE_W'(FRAME_PIXELS);
    end else begin
      size = SIZE_W'(frame_pixels);
    end
  end

  // a shrunk frame ends at the current pixel
  always_comb begin
    if (SIZE_W'(pixel_index) >= size) begin
      pos = POS_W'(size - 1'b1);
    end else begin
      pos = pixel_index;
    end
    last = (SIZE_W'(pos) + 1'b1 >= size);
  end

  // all averaged slots besides the current one must hold a whole frame
  always_comb begin
    gate = 1'b1;
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (k < int'(filter_order) && SLOT_W'(k) != ring_slot && !slot_written[k]) begin
        gate = 1'b0;
      end
    end
  end

  assign slot_inc = {1'b0, ring_slot} + 1'b1;
  assign pix_xfer = pixel.valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_slot    <= '0;
      pixel_index  <= '0;
      slot_written <= '0;
    end else if (pix_xfer) begin
      if (last) begin
        slot_written[ring_slot] <= 1'b1;
        pixel_index             <= '0;
        if (32'(slot_inc) >= 32'(filter_order)) begin
          ring_slot <= '0;
        end else begin
          ring_slot <= slot_inc[SLOT_W-1:0];
        end
      end else begin
        pixel_index <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_xfer) begin
      cur_slot <= ring_slot;
      pos_r    <= pos;
      last_r   <= last;
      gate_r   <= gate;
      pix_r    <= {pixel.in_ch2, pixel.in_ch1, pixel.in_ch0};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign fetch_done = (fetch_idx == filter_order) && !rd_pend;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (pixel.valid) state_next = ST_STORE;
      ST_STORE:  state_next = gate_r ? ST_FETCH : ST_IDLE;
      ST_FETCH:  if (fetch_done) state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_next = ST_EMIT;
      ST_EMIT:   if (!res_valid || result.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pix_ready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:  pix_ready = 1'b1;
      ST_STORE: mem_we = 1'b1;
      ST_FETCH: begin
        mem_re    = (fetch_idx < filter_order);
        div_start = fetch_done;
      end
      ST_EMIT:  out_load = !res_valid || result.ready;
      default: ;
    endcase
  end

  assign pixel.ready = pix_ready;

  // fetch counter and channel sums
  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_idx <= '0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= mem_re;
      if (mem_we) begin
        fetch_idx <= '0;
      end else if (mem_re) begin
        fetch_idx <= fetch_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (mem_we) begin
        sum[c] <= '0;
      end else if (rd_pend) begin
        sum[c] <= sum[c] + SUM_W'(mem_rdata[c*PIX_W +: PIX_W]);
      end
    end
  end

  assign mem_addr = mem_we ? {cur_slot, pos_r} : {SLOT_W'(fetch_idx), pos_r};

  tfa_frame_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (pix_r),
    .rdata (mem_rdata)
  );

  tfa_round_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .order (filter_order),
    .sum   (sum),
    .done  (div_done),
    .quot  (quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        res_ch[c] <= quot[c];
      end
      res_last <= last_r;
    end
  end

  assign result.valid      = res_valid;
  assign result.out_ch0    = res_ch[0];
  assign result.out_ch1    = res_ch[1];
  assign result.out_ch2    = res_ch[2];
  assign result.last_pixel = res_last;

  `TFA_ASSERT(a_div_done_in_divide, div_done |-> state == ST_DIVIDE, "divider finished outside divide")
  `TFA_ASSERT(a_read_in_fetch, rd_pend |-> state == ST_FETCH, "frame read returned outside fetch")
  `TFA_ASSERT_NEXT(a_pixel_stored, pix_xfer, state == ST_STORE, "accepted pixel not stored next")
  `TFA_ASSERT(a_result_from_emit, $rose(res_valid) |-> $past(state) == ST_EMIT, "result without emit")

endmodule

>>> sim/tb_temporal_frame_average.sv
`timescale 1ns / 1ps

module tb_temporal_frame_average;
  import tfa_pkg::*;

  localparam int SLOT_COUNT    = DEF_MAX_ORDER;
  localparam int FRAME_CAP     = DEF_FRAME_PIXELS;
  localparam int SMALL_FRAME   = 24;
  localparam int ITEMS         = 1700;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int LONG_HOLD     = 600;

  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_HI = CFG_IDX_W'(255);

  typedef struct packed {
    pixel_t ch0;
    pixel_t ch1;
    pixel_t ch2;
    logic   last;
  } avg_t;

  // ROW_PIX_EXP carries its own result, ROW_PIX_NONE expects no result
  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_EXP, ROW_PIX_NONE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    pixel_t                c0;
    pixel_t                c1;
    pixel_t                c2;
    avg_t                  want;
  } step_row_t;

  localparam int DIRECTED_LEN = 27;
  localparam step_row_t DIRECTED [DIRECTED_LEN] = '{
    '{ROW_PIX_EXP, '0, '0, 8'h00, 8'h00, 8'h00, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{ROW_PIX_EXP, '0, '0, 8'hFF, 8'hFF, 8'hFF, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
    '{ROW_PIX_EXP, '0, '0, 8'hA5, 8'h5A, 8'h0F, '{8'hA5, 8'h5A, 8'h0F, 1'b0}},
    // shrink below the current position: next pixel closes the frame
    '{ROW_CFG, REG_FRAME_PIXELS, 17'd2, '0, '0, '0, '0},
    '{ROW_PIX_EXP, '0, '0, 8'h01, 8'h02, 8'h03, '{8'h01, 8'h02, 8'h03, 1'b1}},
    // ignored writes
    '{ROW_CFG, REG_FILTER_ORDER, 17'd0, '0, '0, '0, '0},
    '{ROW_CFG, REG_FILTER_ORDER, 17'd8, '0, '0, '0, '0},
    '{ROW_CFG, REG_UNKNOWN_LO, 17'd1, '0, '0, '0, '0},
    '{ROW_CFG, REG_UNKNOWN_HI, 17'h1FFFF, '0, '0, '0, '0},
    '{ROW_PIX_EXP, '0, '0, 8'd10, 8'd20, 8'd30, '{8'd10, 8'd20, 8'd30, 1'b0}},
    '{ROW_PIX_EXP, '0, '0, 8'd40, 8'd50, 8'd60, '{8'd40, 8'd50, 8'd60, 1'b1}},
    // gated until three frames are held
    '{ROW_CFG, REG_FILTER_ORDER, 17'd3, '0, '0, '0, '0},
    '{ROW_PIX_NONE, '0, '0, 8'd0, 8'd0, 8'd0, '0},
    '{ROW_PIX_NONE, '0, '0, 8'd0, 8'd0, 8'd0, '0},
    '{ROW_PIX_NONE, '0, '0, 8'd0, 8'd1, 8'd255, '0},
    '{ROW_PIX_NONE, '0, '0, 8'd1, 8'd1, 8'd255, '0},
    '{ROW_PIX, '0, '0, 8'd1, 8'd1, 8'd254, '0},
    // order lowered while the third slot is being written
    '{ROW_CFG, REG_FILTER_ORDER, 17'd2, '0, '0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd200, 8'd100, 8'd7, '0},
    '{ROW_PIX, '0, '0, 8'd9, 8'd9, 8'd9, '0},
    '{ROW_CFG, REG_FRAME_PIXELS, 17'd0, '0, '0, '0, '0},
    '{ROW_PIX, '0, '0, 8'd3, 8'd4, 8'd5, '0},
    '{ROW_PIX, '0, '0, 8'd6, 8'd7, 8'd8, '0},
    '{ROW_CFG, REG_FRAME_PIXELS, 17'h1FFFF, '0, '0, '0, '0},
    '{ROW_CFG, REG_FILTER_ORDER, 17'd1, '0, '0, '0, '0},
    '{ROW_PIX_EXP, '0, '0, 8'd77, 8'd88, 8'd99, '{8'd77, 8'd88, 8'd99, 1'b0}},
    '{ROW_PIX_EXP, '0, '0, 8'd255, 8'd0, 8'd255, '{8'd255, 8'd0, 8'd255, 1'b0}}
  };

  logic clk;
  logic rst;

  tfa_pix_if pix_bus ();
  tfa_res_if res_bus ();
  tfa_cfg_if cfg_bus ();

  temporal_frame_average DUT (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_bus),
    .result (res_bus),
    .cfg    (cfg_bus)
  );

  // predictor state
  logic [ORDER_W-1:0] order_q = FILTER_ORDER_RST;
  logic [FRAME_W-1:0] fpix_q  = FRAME_PIXELS_RST;
  bit                 slot_done [SLOT_COUNT];
  int unsigned        ring_q = 0;
  int unsigned        pos_q  = 0;
  word_t              frame_mem [int unsigned];

  avg_t        expected_means [$];
  int unsigned pixels_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;
  int unsigned report_count = 0;
  bit          no_idle      = 1'b0;

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_FILTER_ORDER) begin
      if (data[ORDER_W-1:0] != 0 && 32'(data[ORDER_W-1:0]) < SLOT_COUNT) begin
        order_q = data[ORDER_W-1:0];
      end
    end else if (idx == REG_FRAME_PIXELS) begin
      fpix_q = data;
    end
  endfunction

  function automatic bit average_pixel(input pixel_t c0, input pixel_t c1, input pixel_t c2,
                                       output avg_t res);
    int unsigned size, pos, n, k, s0, s1, s2;
    bit          full;
    bit          last;
    word_t       w;
    full = 1'b1;
    s0 = 0;
    s1 = 0;
    s2 = 0;
    size = (fpix_q == 0) ? 1 : (fpix_q > FRAME_CAP) ? FRAME_CAP : fpix_q;
    pos = (pos_q >= size) ? size - 1 : pos_q;
    last = (pos + 1 >= size);
    frame_mem[ring_q * FRAME_CAP + pos] = {c2, c1, c0};
    n = order_q;
    for (k = 0; k < n; k++) begin
      if (k != ring_q && !slot_done[k]) begin
        full = 1'b0;
        break;
      end
      // the stimulus never reads an entry that was not written
      w = frame_mem.exists(k * FRAME_CAP + pos) ? frame_mem[k * FRAME_CAP + pos] : '0;
      s0 += w[7:0];
      s1 += w[15:8];
      s2 += w[23:16];
    end
    if (last) begin
      slot_done[ring_q] = 1'b1;
      pos_q = 0;
      ring_q = (ring_q + 1 >= n) ? 0 : ring_q + 1;
    end else begin
      pos_q = pos + 1;
    end
    // exact sum, rounded half up
    res.ch0 = pixel_t'((2 * s0 + n) / (2 * n));
    res.ch1 = pixel_t'((2 * s1 + n) / (2 * n));
    res.ch2 = pixel_t'((2 * s2 + n) / (2 * n));
    res.last = last;
    return full;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_pixel(input pixel_t c0, input pixel_t c1, input pixel_t c2,
                            input bit fixed, input bit fixed_has, input avg_t fixed_res);
    int unsigned gap, r;
    bit          has;
    avg_t        got;
    gap = 0;
    if (!no_idle) begin
      r = $urandom_range(0, 99);
      if (r < 40) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      @(negedge clk);
      pix_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_bus.valid  <= 1'b1;
    pix_bus.in_ch0 <= c0;
    pix_bus.in_ch1 <= c1;
    pix_bus.in_ch2 <= c2;
    do @(posedge clk); while (!pix_bus.ready);
    has = average_pixel(c0, c1, c2, got);
    if (fixed) begin
      has = fixed_has;
      got = fixed_res;
    end
    if (has) expected_means.push_back(got);
    pixels_sent++;
  endtask

  // stop offering pixels and let every pending result come out
  task automatic drain();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    pix_bus.valid <= 1'b0;
    while (expected_means.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    apply_register(idx, data);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // result sink with random stalls and one long hold-off
  initial begin
    int unsigned hold_left;
    int unsigned r;
    bit          long_done;
    hold_left = 0;
    long_done = 1'b0;
    res_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (!long_done && results_seen >= 400) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
        res_bus.ready <= 1'b0;
      end else if (no_idle) begin
        res_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) hold_left = $urandom_range(8, 50);
        res_bus.ready <= (r >= 30);
      end
    end
  end

  always @(posedge clk) begin : check_results
    avg_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (expected_means.size() == 0) begin
        fail_count++;
        if (report_count < 10) begin
          $display("unexpected result: got %0d %0d %0d last %0b", res_bus.out_ch0,
                   res_bus.out_ch1, res_bus.out_ch2, res_bus.last_pixel);
          report_count++;
        end
      end else begin
        want = expected_means.pop_front();
        if (res_bus.out_ch0 !== want.ch0 || res_bus.out_ch1 !== want.ch1 ||
            res_bus.out_ch2 !== want.ch2 || res_bus.last_pixel !== want.last) begin
          fail_count++;
          if (report_count < 10) begin
            $display("mismatch at result %0d: expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
                     results_seen, want.ch0, want.ch1, want.ch2, want.last, res_bus.out_ch0,
                     res_bus.out_ch1, res_bus.out_ch2, res_bus.last_pixel);
            report_count++;
          end
        end
      end
    end
  end

  initial begin
    step_row_t             row;
    int unsigned           count, order, r;
    logic [CFG_DATA_W-1:0] size;
    rst            <= 1'b1;
    pix_bus.valid  <= 1'b0;
    pix_bus.in_ch0 <= '0;
    pix_bus.in_ch1 <= '0;
    pix_bus.in_ch2 <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= '0;
    cfg_bus.data   <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      row = DIRECTED[i];
      case (row.kind)
        ROW_CFG:      write_reg(row.idx, row.val);
        ROW_PIX:      send_pixel(row.c0, row.c1, row.c2, 1'b0, 1'b0, '0);
        ROW_PIX_EXP:  send_pixel(row.c0, row.c1, row.c2, 1'b1, 1'b1, row.want);
        ROW_PIX_NONE: send_pixel(row.c0, row.c1, row.c2, 1'b1, 1'b0, '0);
        default:      ;
      endcase
    end

    // close the open frame so the ring restarts at slot zero, then fill
    // every slot at the small frame size before mixing settings
    write_reg(REG_FILTER_ORDER, 17'd1);
    write_reg(REG_FRAME_PIXELS, 17'd1);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, '0);
    write_reg(REG_FILTER_ORDER, 17'(SLOT_COUNT - 1));
    write_reg(REG_FRAME_PIXELS, 17'(SMALL_FRAME));
    repeat ((SLOT_COUNT - 1) * SMALL_FRAME)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, '0);

    while (pixels_sent < ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) begin
        // low bits clear: a multiple of eight, so the order field is zero and ignored
        write_reg(REG_FILTER_ORDER, 17'($urandom_range(0, 16383) << ORDER_W));
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), 17'($urandom));
      end
      if ($urandom_range(0, 9) == 0) begin
        // a single slot reads back only slot zero: the pixel just stored once the ring is at zero, any size is safe
        write_reg(REG_FILTER_ORDER, 17'd1);
        case ($urandom_range(0, 3))
          0:       size = 17'(FRAME_CAP);
          1:       size = 17'($urandom_range(FRAME_CAP + 1, 131071));
          2:       size = 17'($urandom_range(SMALL_FRAME + 1, FRAME_CAP - 1));
          default: size = '0;
        endcase
        write_reg(REG_FRAME_PIXELS, size);
        count = $urandom_range(1, 40);
      end else begin
        r = $urandom_range(0, 9);
        order = (r < 3) ? SLOT_COUNT - 1 : (r < 5) ? 1 : $urandom_range(2, SLOT_COUNT - 2);
        r = $urandom_range(0, 9);
        size = (r == 0) ? '0 : (r < 3) ? 17'(SMALL_FRAME) : 17'($urandom_range(1, SMALL_FRAME));
        write_reg(REG_FILTER_ORDER, 17'(order));
        write_reg(REG_FRAME_PIXELS, size);
        count = $urandom_range(1, 60);
      end
      repeat (count) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, '0);
    end

    no_idle = 1'b0;
    drain();
    fail_count += expected_means.size();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/tfa_pkg.sv
hdl/tfa_if.sv
hdl/tfa_frame_mem.sv
hdl/tfa_round_div.sv
hdl/temporal_frame_average.sv
sim/tb_temporal_frame_average.sv
